### sv/skff_pkg.sv
`timescale 1ns / 1ps

package skff_pkg;

  // Field and register widths.
  localparam int unsigned FORCE_W    = 32;  // signed Q16.16
  localparam int unsigned VAR_W      = 32;  // unsigned Q4.28
  localparam int unsigned GAIN_W     = 18;  // unsigned Q2.16
  localparam int unsigned KGAIN_W    = 29;  // unsigned Q1.28, up to 1.0
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PC_W       = 4;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 29;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

  // Quotient bits produced by the shift-subtract loop after the top bit.
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(28);

  localparam logic [KGAIN_W-1:0] ONE_Q28 = KGAIN_W'(1) << 28;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(65536);
  localparam logic [VAR_W-1:0]  QNOISE_RESET = VAR_W'(26844);
  localparam logic [VAR_W-1:0]  RNOISE_RESET = VAR_W'(13421773);
  localparam logic [VAR_W-1:0]  PINIT_RESET  = VAR_W'(271119319);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = CFG_IDX_W'(3);

  // Datapath operation of one microinstruction.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,        // latch the measurement on an input transaction
    OP_SCALE_AP,    // round A*P, form innovation magnitude and sign
    OP_PREDICT,     // round A*P*A, add Q, saturate to Pp
    OP_DIV_INIT,    // set up the gain division Pp / (Pp + R)
    OP_DIV_STEP,    // one restoring shift-subtract step
    OP_ONE_MINUS_K, // form 1 - K
    OP_CORRECT,     // apply the rounded correction to the estimate
    OP_UPDATE_VAR,  // round (1 - K) * Pp into the variance
    OP_FIRST,       // first sample: load the variance, clear the estimate
    OP_EMIT         // hand the result to the output register
  } op_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MS_NONE,
    MS_PA,     // P * A
    MS_APA,    // (A*P) * A
    MS_CORR,   // |z - x| * K
    MS_VAR     // Pp * (1 - K)
  } mul_sel_t;

  // Sequencer branch kind.
  typedef enum logic [2:0] {
    BR_NEXT,   // go on to the next step
    BR_INPUT,  // hold until a transaction; then next, or target before start
    BR_LOOP,   // repeat this step until the divide counter runs out
    BR_OUTPUT, // hold until the output register is free, then jump to target
    BR_JUMP    // jump to target
  } br_t;

  typedef struct packed {
    op_t             op;
    mul_sel_t        mul;
    br_t             br;
    logic [PC_W-1:0] target;
  } uinst_t;

  typedef struct packed {
    logic started;
    logic div_last;
  } dp_status_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [VAR_W-1:0]  qnoise;
    logic [VAR_W-1:0]  rnoise;
    logic [VAR_W-1:0]  pinit;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_FIRST = PC_W'(11);

  // Microprogram store.
  function automatic uinst_t skff_ucode(input logic [PC_W-1:0] pc);
    uinst_t u;
    u = '{op: OP_NOP, mul: MS_NONE, br: BR_JUMP, target: PC_IDLE};
    unique case (pc)
      PC_W'(0):  u = '{op: OP_LOAD,        mul: MS_NONE, br: BR_INPUT,  target: PC_FIRST};
      PC_W'(1):  u = '{op: OP_NOP,         mul: MS_PA,   br: BR_NEXT,   target: PC_IDLE};
      PC_W'(2):  u = '{op: OP_SCALE_AP,    mul: MS_NONE, br: BR_NEXT,   target: PC_IDLE};
      PC_W'(3):  u = '{op: OP_NOP,         mul: MS_APA,  br: BR_NEXT,   target: PC_IDLE};
      PC_W'(4):  u = '{op: OP_PREDICT,     mul: MS_NONE, br: BR_NEXT,   target: PC_IDLE};
      PC_W'(5):  u = '{op: OP_DIV_INIT,    mul: MS_NONE, br: BR_NEXT,   target: PC_IDLE};
      PC_W'(6):  u = '{op: OP_DIV_STEP,    mul: MS_NONE, br: BR_LOOP,   target: PC_IDLE};
      PC_W'(7):  u = '{op: OP_ONE_MINUS_K, mul: MS_CORR, br: BR_NEXT,   target: PC_IDLE};
      PC_W'(8):  u = '{op: OP_CORRECT,     mul: MS_VAR,  br: BR_NEXT,   target: PC_IDLE};
      PC_W'(9):  u = '{op: OP_UPDATE_VAR,  mul: MS_NONE, br: BR_NEXT,   target: PC_IDLE};
      PC_W'(10): u = '{op: OP_EMIT,        mul: MS_NONE, br: BR_OUTPUT, target: PC_IDLE};
      PC_W'(11): u = '{op: OP_FIRST,       mul: MS_NONE, br: BR_JUMP,   target: PC_EMIT};
      default:   u = '{op: OP_NOP,         mul: MS_NONE, br: BR_JUMP,   target: PC_IDLE};
    endcase
    return u;
  endfunction

endpackage

### sv/skff_datapath.sv
`timescale 1ns / 1ps

module skff_datapath import skff_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  uinst_t                    uinst,
  input  logic                      in_take,
  input  logic                      in_contact,
  input  logic signed [FORCE_W-1:0] in_force,
  input  cfg_t                      cfg,
  output dp_status_t                status,
  output logic signed [FORCE_W-1:0] estimate,
  output logic signed [FORCE_W-1:0] meas
);

  logic [VAR_W-1:0]     variance;
  logic                 started;
  logic [PROD_W-1:0]    prod;
  logic [MUL_A_W-1:0]   ap;
  logic [VAR_W-1:0]     pp;
  logic [VAR_W:0]       den;
  logic                 den_zero;
  logic [MUL_A_W-1:0]   rem;
  logic [KGAIN_W-1:0]   quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FORCE_W:0]     mag;
  logic                 neg;
  logic [KGAIN_W-1:0]   onemk;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     rnd16;
  logic [PROD_W-1:0]     rnd28;
  logic [VAR_W+4:0]      pred_sum;
  logic [VAR_W-1:0]      pp_next;
  logic [KGAIN_W-1:0]    keff;
  logic [MUL_A_W-1:0]    rem_shl;
  logic [MUL_A_W:0]      trial;
  logic signed [FORCE_W:0]   innov;
  logic signed [FORCE_W+2:0] corr;
  logic signed [FORCE_W+2:0] est_sum;
  logic signed [FORCE_W-1:0] est_next;
  logic [FORCE_W+2:0]    var_wide;
  logic [VAR_W-1:0]      var_next;

  assign keff = den_zero ? '0 : quot;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uinst.mul)
      MS_PA: begin
        mul_a = MUL_A_W'(variance);
        mul_b = MUL_B_W'(cfg.gain);
      end
      MS_APA: begin
        mul_a = ap;
        mul_b = MUL_B_W'(cfg.gain);
      end
      MS_CORR: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(keff);
      end
      MS_VAR: begin
        mul_a = MUL_A_W'(pp);
        mul_b = MUL_B_W'(onemk);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rnd16    = prod + (PROD_W'(1) << 15);
    rnd28    = prod + (PROD_W'(1) << 27);
    pred_sum = (VAR_W+5)'(rnd16[51:16]) + (VAR_W+5)'(cfg.qnoise);
    pp_next  = (pred_sum[VAR_W+4:VAR_W] != '0) ? '1 : pred_sum[VAR_W-1:0];

    rem_shl = {rem[MUL_A_W-2:0], 1'b0};
    trial   = {1'b0, rem_shl} - (MUL_A_W+1)'(den);

    innov = {meas[FORCE_W-1], meas} - {estimate[FORCE_W-1], estimate};

    corr = neg ? -$signed((FORCE_W+3)'({1'b0, rnd28[60:28]}))
               :  $signed((FORCE_W+3)'({1'b0, rnd28[60:28]}));
    est_sum = $signed({{3{estimate[FORCE_W-1]}}, estimate}) + corr;
    if (est_sum[FORCE_W+2:FORCE_W-1] == '0 || est_sum[FORCE_W+2:FORCE_W-1] == '1) begin
      est_next = est_sum[FORCE_W-1:0];
    end else if (est_sum[FORCE_W+2]) begin
      est_next = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      est_next = {1'b0, {(FORCE_W-1){1'b1}}};
    end

    var_wide = rnd28[62:28];
    var_next = (var_wide[FORCE_W+2:VAR_W] != '0) ? '1 : var_wide[VAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (uinst.mul != MS_NONE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    case (uinst.op)
      OP_LOAD: begin
        if (in_take) begin
          meas <= in_contact ? in_force : '0;
        end
      end
      OP_SCALE_AP: begin
        ap  <= rnd16[49:16];
        neg <= innov[FORCE_W];
        mag <= innov[FORCE_W] ? $unsigned(-innov) : $unsigned(innov);
      end
      OP_PREDICT: begin
        pp <= pp_next;
      end
      OP_DIV_INIT: begin
        // With R of zero the gain is one (or zero when Pp is zero too).
        den      <= {1'b0, pp} + {1'b0, cfg.rnoise};
        den_zero <= (pp == '0) && (cfg.rnoise == '0);
        rem      <= (cfg.rnoise == '0) ? '0 : MUL_A_W'(pp);
        quot     <= KGAIN_W'((cfg.rnoise == '0) && (pp != '0));
        cnt      <= DIV_STEPS;
      end
      OP_DIV_STEP: begin
        if (!trial[MUL_A_W]) begin
          rem  <= trial[MUL_A_W-1:0];
          quot <= {quot[KGAIN_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shl;
          quot <= {quot[KGAIN_W-2:0], 1'b0};
        end
        cnt <= cnt - DIV_CNT_W'(1);
      end
      OP_ONE_MINUS_K: begin
        onemk <= ONE_Q28 - keff;
      end
      default: begin
      end
    endcase

    if (rst) begin
      started  <= 1'b0;
      estimate <= '0;
      variance <= '0;
    end else begin
      case (uinst.op)
        OP_CORRECT:    estimate <= est_next;
        OP_UPDATE_VAR: variance <= var_next;
        OP_FIRST: begin
          started  <= 1'b1;
          estimate <= '0;
          variance <= cfg.pinit;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.started  = started;
  assign status.div_last = (cnt == DIV_CNT_W'(1));

endmodule

### sv/scalar_kalman_force_filter.sv
`timescale 1ns / 1ps
// A result is valid once its input has run through the microprogram, sooner for the
// first sample after reset, which only loads the variance and clears the estimate.
// Samples are taken one at a time; the 28-step shift-subtract loop of the gain
// divider takes most of each one, the rest is four passes through the shared multiplier.
// Reset (rst, synchronous, active high) clears the estimate, the variance and the
// started flag, returns the sequencer to idle and reloads all registers to defaults.

module scalar_kalman_force_filter import skff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream, one force sample per transaction.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [FORCE_W-1:0]    s_axis_tdata,   // [31:0] force_sample
  input  logic                  s_axis_tuser,   // [0] contact_present
  // Output stream, one result per sample.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*FORCE_W-1:0]  m_axis_tdata,   // [31:0] filtered_force, [63:32] used_measurement
  // Configuration writes.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The filter is run by a small microprogram. Each step's control word picks
  // a datapath operation, a multiplier operand pair and a branch. The idle step
  // waits for a transaction; the divide step repeats until its counter is done;
  // the emit step waits for the output register to be free.

  cfg_t                      cfg;
  logic [PC_W-1:0]           pc;
  logic [PC_W-1:0]           pc_next;
  uinst_t                    uinst;
  dp_status_t                status;
  logic                      in_take;
  logic                      out_free;
  logic signed [FORCE_W-1:0] estimate;
  logic signed [FORCE_W-1:0] meas;

  assign uinst         = skff_ucode(pc);
  // Nothing is taken while reset is held, so no transaction can be lost to it.
  assign s_axis_tready = !rst && (uinst.br == BR_INPUT);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  // The output register is a one-entry buffer, so the next sample can be taken
  // and worked on while the previous result still waits.
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    pc_next = pc;
    unique case (uinst.br)
      BR_NEXT:   pc_next = pc + PC_W'(1);
      BR_INPUT: begin
        if (in_take) begin
          pc_next = status.started ? pc + PC_W'(1) : uinst.target;
        end
      end
      BR_LOOP:   pc_next = status.div_last ? pc + PC_W'(1) : pc;
      BR_OUTPUT: pc_next = out_free ? uinst.target : pc;
      BR_JUMP:   pc_next = uinst.target;
      default:   pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= PC_IDLE;
      m_axis_tvalid <= 1'b0;
      cfg.gain      <= GAIN_RESET;
      cfg.qnoise    <= QNOISE_RESET;
      cfg.rnoise    <= RNOISE_RESET;
      cfg.pinit     <= PINIT_RESET;
    end else begin
      pc <= pc_next;
      if (uinst.op == OP_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {meas, estimate};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // Writes to indexes beyond the register list are dropped.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TRANSITION_GAIN:   cfg.gain   <= cfg_data[GAIN_W-1:0];
          REG_PROCESS_NOISE:     cfg.qnoise <= cfg_data[VAR_W-1:0];
          REG_MEASUREMENT_NOISE: cfg.rnoise <= cfg_data[VAR_W-1:0];
          REG_INITIAL_VARIANCE:  cfg.pinit  <= cfg_data[VAR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  skff_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .uinst      (uinst),
    .in_take    (in_take),
    .in_contact (s_axis_tuser),
    .in_force   (s_axis_tdata),
    .cfg        (cfg),
    .status     (status),
    .estimate   (estimate),
    .meas       (meas)
  );

endmodule

### sv/skff_checker.sv
`timescale 1ns / 1ps

module skff_checker import skff_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [2*FORCE_W-1:0] m_axis_tdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // One sample at a time: the input closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready after a transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind scalar_kalman_force_filter skff_checker u_skff_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_scalar_kalman_force_filter.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_force_filter;
  import skff_pkg::*;

  // One force sample as it enters the filter, and the pair of values that the filter
  // reports for it.
  typedef struct packed {
    logic                      contact;
    logic signed [FORCE_W-1:0] force_q16;
  } sample_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] filtered;
    logic signed [FORCE_W-1:0] measured;
  } force_result_t;

  localparam longint EST_MAX = 64'sd2147483647;
  localparam longint EST_MIN = -64'sd2147483648;
  localparam logic [63:0] Q28_ONE = 64'd1 << 28;
  localparam logic [63:0] Q28_HALF = 64'd1 << 27;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_INITIAL_VARIANCE + 1'b1;

  // Clock, reset and every input of the block start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [FORCE_W-1:0] s_axis_tdata = '0;     // [31:0] force_sample
  logic s_axis_tuser = 1'b0;                 // [0] contact_present
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*FORCE_W-1:0] m_axis_tdata;        // [31:0] filtered_force, [63:32] used_measurement
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scalar_kalman_force_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The filter as the testbench sees it: a copy of the four registers and of the
  // three state values, all at their reset values.
  logic [GAIN_W-1:0] model_gain = GAIN_RESET;
  logic [VAR_W-1:0] model_qnoise = QNOISE_RESET;
  logic [VAR_W-1:0] model_rnoise = RNOISE_RESET;
  logic [VAR_W-1:0] model_pinit = PINIT_RESET;
  logic model_started = 1'b0;
  logic signed [FORCE_W-1:0] model_estimate = '0;
  logic [VAR_W-1:0] model_variance = '0;

  sample_t pending_samples[$];
  force_result_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;

  // Runs one filter step on the model state and returns what the block must report.
  // All products fit in 64 bits: A*P < 2^50, A*(A*P) < 2^52, |z-x|*K <= 2^61.
  function automatic force_result_t kalman_update(input sample_t s);
    logic signed [FORCE_W-1:0] z;
    logic [63:0] ap, apa, pp_sum, den, gain_k, mag, corr_mag, var_next;
    logic [VAR_W-1:0] pp;
    longint innov, est_next;
    force_result_t r;
    z = s.contact ? s.force_q16 : '0;
    if (!model_started) begin
      // The first sample only seeds the filter; its measurement is not used.
      model_variance = model_pinit;
      model_estimate = '0;
      model_started = 1'b1;
    end else begin
      ap = (64'(model_variance) * 64'(model_gain) + 64'd32768) >> 16;
      apa = (ap * 64'(model_gain) + 64'd32768) >> 16;
      pp_sum = apa + 64'(model_qnoise);
      pp = (pp_sum > 64'hFFFF_FFFF) ? '1 : pp_sum[VAR_W-1:0];
      den = 64'(pp) + 64'(model_rnoise);
      // With a zero denominator the gain is taken as zero.
      gain_k = (den != 64'd0) ? ((64'(pp) << 28) / den) : 64'd0;
      innov = longint'(z) - longint'(model_estimate);
      mag = (innov < 0) ? 64'(-innov) : 64'(innov);
      // The correction is rounded half away from zero: round the magnitude, then sign it.
      corr_mag = (mag * gain_k + Q28_HALF) >> 28;
      est_next = longint'(model_estimate)
                 + ((innov < 0) ? -longint'(corr_mag) : longint'(corr_mag));
      if (est_next > EST_MAX) begin
        model_estimate = 32'sh7FFF_FFFF;
      end else if (est_next < EST_MIN) begin
        model_estimate = 32'sh8000_0000;
      end else begin
        model_estimate = est_next[FORCE_W-1:0];
      end
      var_next = ((Q28_ONE - gain_k) * 64'(pp) + Q28_HALF) >> 28;
      model_variance = (var_next > 64'hFFFF_FFFF) ? '1 : var_next[VAR_W-1:0];
    end
    r.filtered = model_estimate;
    r.measured = z;
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then long, and every so often a calm
  // stretch in which no idling happens at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 200);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 20);
    return $urandom_range(21, 100);
  endfunction

  function automatic logic [VAR_W-1:0] pick_variance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Random samples: mostly with contact, mixing full-range values, the two extremes
  // and small forces of either sign so the estimate has something to track.
  function automatic sample_t pick_sample();
    sample_t s;
    s.contact = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0: s.force_q16 = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2, 3: s.force_q16 = $urandom();
      default: s.force_q16 = $signed($urandom()) >>> $urandom_range(8, 24);
    endcase
    return s;
  endfunction

  task automatic queue_sample(input logic contact, input logic [FORCE_W-1:0] value);
    pending_samples.push_back('{contact: contact, force_q16: value});
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [FORCE_W-1:0] want,
                             input logic [FORCE_W-1:0] got);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s: expected %h, got %h",
                              result_index, name, want, got));
    end
  endtask

  // Writes all four registers plus one index that has no register behind it. Must be
  // called right after a rising edge while the block is idle; the write enable is
  // dropped only after the last write so it never toggles within one time step.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] gain_word,
                                input logic [VAR_W-1:0] qnoise, rnoise, pinit);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DATA_W-1:0] word [5];
    idx[0] = REG_TRANSITION_GAIN;   word[0] = gain_word;
    idx[1] = REG_PROCESS_NOISE;     word[1] = qnoise;
    idx[2] = REG_MEASUREMENT_NOISE; word[2] = rnoise;
    idx[3] = REG_INITIAL_VARIANCE;  word[3] = pinit;
    idx[4] = $urandom_range(REG_UNUSED_FIRST, {CFG_IDX_W{1'b1}});
    word[4] = $urandom();
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= word[i];
      @(posedge clk);
      case (idx[i])
        REG_TRANSITION_GAIN:   model_gain = word[i][GAIN_W-1:0];
        REG_PROCESS_NOISE:     model_qnoise = word[i];
        REG_MEASUREMENT_NOISE: model_rnoise = word[i];
        REG_INITIAL_VARIANCE:  model_pinit = word[i];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Waits, looking at settled values on the falling edge, until nothing is queued,
  // nothing is offered and no result is outstanding; returns on a rising edge.
  task automatic wait_quiet();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Sample driver. Each accepted transaction is run through the model right away, so
  // the expected result is queued in the same cycle the block takes the sample. Valid
  // is assigned at most once per edge, which keeps back-to-back samples clean.
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;

  always @(posedge clk) begin : sample_driver
    sample_t taken, nxt;
    logic fire;
    if (!rst) begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        taken.contact = s_axis_tuser;
        taken.force_q16 = s_axis_tdata;
        expected_results.push_back(kalman_update(taken));
        send_gap = pick_gap(send_calm);
      end
      if (fire || !s_axis_tvalid) begin
        if (send_gap == 0 && pending_samples.size() != 0) begin
          nxt = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.force_q16;
          s_axis_tuser <= nxt.contact;
        end else begin
          if (send_gap != 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Compares every output transaction with the oldest expectation and
  // stalls the output side at random so back-pressure lands at any point of a result.
  int unsigned stall_left = 0;
  int unsigned ready_calm = 0;

  always @(posedge clk) begin : result_monitor
    force_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing pending: %h",
                                result_index, m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        check_field("filtered_force", want.filtered, m_axis_tdata[FORCE_W-1:0]);
        check_field("used_measurement", want.measured, m_axis_tdata[2*FORCE_W-1:FORCE_W]);
      end
      result_index++;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = pick_gap(ready_calm);
    end
  end

  // Stimulus and phase control.
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] gain_word;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first sample seeds the filter with the largest initial
    // variance; it must report a zero estimate and still echo its measurement.
    apply_settings(32'(GAIN_RESET), QNOISE_RESET, RNOISE_RESET, '1);
    @(negedge clk);
    queue_sample(1'b1, 32'h7FFF_FFFF);
    queue_sample(1'b1, 32'h8000_0000);
    queue_sample(1'b1, 32'h7FFF_FFFF);
    queue_sample(1'b0, 32'h7FFF_FFFF);   // no contact: measurement reads as zero
    queue_sample(1'b0, 32'h8000_0000);
    queue_sample(1'b1, 32'h0000_0000);
    queue_sample(1'b1, 32'hFFFF_FFFF);
    queue_sample(1'b1, 32'h0000_0001);
    queue_sample(1'b0, 32'hA5A5_A5A5);
    queue_sample(1'b1, 32'h0001_0000);
    queue_sample(1'b1, 32'hFFFF_0000);
    wait_quiet();

    // Zero transition gain and zero noise make Pp + R zero, so the gain is zero and
    // the estimate has to hold however far the measurement jumps.
    apply_settings('0, '0, '0, $urandom());
    @(negedge clk);
    queue_sample(1'b1, 32'h7FFF_FFFF);
    queue_sample(1'b1, 32'h8000_0000);
    queue_sample(1'b0, 32'h1234_5678);
    wait_quiet();

    // Gain register beyond its nominal range (all ones on the bus, masked to 18 bits),
    // saturated process noise and no measurement noise: the gain becomes exactly one.
    apply_settings('1, '1, '0, '0);
    @(negedge clk);
    queue_sample(1'b1, 32'h8000_0000);
    queue_sample(1'b1, 32'h7FFF_FFFF);
    queue_sample(1'b0, 32'h5555_AAAA);
    queue_sample(1'b1, 32'hC000_0001);
    wait_quiet();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings(32'(GAIN_RESET), QNOISE_RESET, RNOISE_RESET, PINIT_RESET);
        1: apply_settings('1, '1, '1, '1);
        2: apply_settings(32'd131072, '0, '1, '0);
        default: begin
          case ($urandom_range(0, 4))
            0: gain_word = '0;
            1: gain_word = 32'd131072;
            2: gain_word = 32'h0003_FFFF;
            3: gain_word = $urandom();
            default: gain_word = $urandom_range(0, 131072);
          endcase
          apply_settings(gain_word, pick_variance(), pick_variance(), pick_variance());
        end
      endcase
      @(negedge clk);
      repeat (115) pending_samples.push_back(pick_sample());
      wait_quiet();
    end

    // Let a stray result show up if the block were to produce one.
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
